[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the record converter.
// Both macros assume a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASRT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASRT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASRT_ALWAYS(lbl, expr, msg)
`define ASRT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/avcc_pkg.sv]
// Shared types and constants for the configuration record to Annex B converter.
// Used by the parser, the command queue, the emitter and the top level.
`timescale 1ns / 1ps
package avcc_pkg;

  // Result status codes.
  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_BADVER = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  localparam logic [7:0] VERSION_ONE    = 8'h01;
  localparam logic [7:0] START_CODE_END = 8'h01;
  localparam logic [7:0] START_CODE_PAD = 8'h00;
  localparam logic [4:0] SEQ_COUNT_MASK = 5'h1f;
  localparam logic [1:0] LEN_SIZE_MASK  = 2'h3;
  localparam logic [2:0] HDR_LAST_IDX   = 3'd5;
  localparam logic [2:0] HDR_PROFILE    = 3'd1;
  localparam logic [2:0] HDR_LEVEL      = 3'd3;
  localparam logic [2:0] HDR_LEN_SIZE   = 3'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Everything one accepted input byte asks the emitter to send.
  typedef struct packed {
    logic       sc;        // start code of four bytes
    logic       sc_end;    // zero-length unit: start code ends the unit
    logic       data;      // one payload byte
    logic [7:0] data_byte;
    logic       data_end;
    logic       kind;      // picture set when set
    logic [1:0] status;    // ST_BYTE means no status result
    logic [7:0] profile;
    logic [7:0] level;
    logic [2:0] nal_len;
  } cmd_t;

endpackage

[hw/rtl/avcc_parse.sv]
// Front part: parses the configuration record one byte per item and builds commands.
// Depends on avcc_pkg.
`timescale 1ns / 1ps
module avcc_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push,
  output avcc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_PPS_COUNT, PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  units_r, units_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        in_pps_r, in_pps_nxt;
  logic [7:0]  profile_r, profile_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [2:0]  nal_len_r, nal_len_nxt;
  logic        fin;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    units_nxt      = units_r;
    len_hi_nxt     = len_hi_r;
    bytes_left_nxt = bytes_left_r;
    in_pps_nxt     = in_pps_r;
    profile_nxt    = profile_r;
    level_nxt      = level_r;
    nal_len_nxt    = nal_len_r;
    fin            = 1'b0;
    cmd            = '0;
    cmd.status     = avcc_pkg::ST_BYTE;
    cmd.kind       = in_pps_r;
    cmd.data_byte  = in_byte;

    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r == 3'd0 && in_byte != avcc_pkg::VERSION_ONE) begin
            cmd.status = avcc_pkg::ST_BADVER;
            phase_nxt  = PH_SKIP;
          end else begin
            if (hdr_idx_r == avcc_pkg::HDR_PROFILE) profile_nxt = in_byte;
            if (hdr_idx_r == avcc_pkg::HDR_LEVEL) level_nxt = in_byte;
            if (hdr_idx_r == avcc_pkg::HDR_LEN_SIZE) begin
              nal_len_nxt = 3'd1 + {1'b0, in_byte[1:0] & avcc_pkg::LEN_SIZE_MASK};
            end
            if (hdr_idx_r == avcc_pkg::HDR_LAST_IDX) begin
              hdr_idx_nxt = 3'd0;
              in_pps_nxt  = 1'b0;
              units_nxt   = {3'd0, in_byte[4:0] & avcc_pkg::SEQ_COUNT_MASK};
              phase_nxt   = (units_nxt != 8'd0) ? PH_LEN_HI : PH_PPS_COUNT;
            end else begin
              hdr_idx_nxt = hdr_idx_r + 3'd1;
            end
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = in_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          bytes_left_nxt = {len_hi_r, in_byte};
          cmd.sc         = 1'b1;
          cmd.sc_end     = (bytes_left_nxt == 16'd0);
          if (bytes_left_nxt == 16'd0) fin = 1'b1;
          else phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          bytes_left_nxt = bytes_left_r - 16'd1;
          cmd.data       = 1'b1;
          cmd.data_end   = (bytes_left_nxt == 16'd0);
          fin            = (bytes_left_nxt == 16'd0);
        end
        PH_PPS_COUNT: begin
          units_nxt  = in_byte;
          in_pps_nxt = 1'b1;
          if (in_byte == 8'd0) begin
            cmd.status = avcc_pkg::ST_DONE;
            phase_nxt  = PH_SKIP;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_SKIP: begin
        end
        default: begin
          phase_nxt   = PH_HEADER;
          hdr_idx_nxt = 3'd0;
        end
      endcase

      // End of one unit: move to the next unit, the picture set count or completion.
      if (fin) begin
        units_nxt = units_r - 8'd1;
        if (units_nxt != 8'd0) begin
          phase_nxt = PH_LEN_HI;
        end else if (!in_pps_r) begin
          phase_nxt = PH_PPS_COUNT;
        end else begin
          cmd.status = avcc_pkg::ST_DONE;
          phase_nxt  = PH_SKIP;
        end
      end

      // An unused phase code only returns to the header phase, even on the last byte.
      if (in_last && phase_r <= PH_SKIP) begin
        if (phase_nxt != PH_SKIP) cmd.status = avcc_pkg::ST_TRUNC;
        phase_nxt   = PH_HEADER;
        hdr_idx_nxt = 3'd0;
      end
    end

    cmd.profile = profile_nxt;
    cmd.level   = level_nxt;
    cmd.nal_len = nal_len_nxt;
    push = accept && (cmd.sc || cmd.data || cmd.status != avcc_pkg::ST_BYTE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= 3'd0;
      units_r      <= 8'd0;
      len_hi_r     <= 8'd0;
      bytes_left_r <= 16'd0;
      in_pps_r     <= 1'b0;
      profile_r    <= 8'd0;
      level_r      <= 8'd0;
      nal_len_r    <= 3'd1;
    end else begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      units_r      <= units_nxt;
      len_hi_r     <= len_hi_nxt;
      bytes_left_r <= bytes_left_nxt;
      in_pps_r     <= in_pps_nxt;
      profile_r    <= profile_nxt;
      level_r      <= level_nxt;
      nal_len_r    <= nal_len_nxt;
    end
  end

endmodule

[hw/rtl/avcc_fifo.sv]
// Short command queue between the parser and the emitter.
// Depends on avcc_pkg for the command type and the depth.
`timescale 1ns / 1ps
module avcc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  avcc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output avcc_pkg::cmd_t    head_cmd
);

  avcc_pkg::cmd_t                  slot_r [avcc_pkg::FIFO_DEPTH];
  logic [avcc_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [avcc_pkg::FIFO_CW-1:0]    count_r;
  logic                            do_push, do_pop;

  assign full       = (count_r == avcc_pkg::FIFO_CW'(avcc_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[hw/rtl/avcc_emit.sv]
// Back part: expands each queued command into result items, one item per cycle while the output is ready.
// Depends on avcc_pkg for the command type and status codes.
`timescale 1ns / 1ps
module avcc_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  avcc_pkg::cmd_t    head_cmd,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [4:0]        out_tuser,
  output logic              out_tlast
);

  typedef enum logic [2:0] {
    SL_SC0, SL_SC1, SL_SC2, SL_SC3, SL_DATA, SL_STAT
  } slot_t;

  slot_t       slot_r, slot_nxt, cur;
  logic        started_r;
  logic        is_last, has_stat, load;
  logic        out_valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        ustart_r, ustart_nxt, uend_r, uend_nxt, kind_r, kind_nxt;
  logic        last_r;
  logic [7:0]  profile_r, level_r;
  logic [2:0]  nal_len_r;

  always_comb begin
    has_stat = (head_cmd.status != avcc_pkg::ST_BYTE);
    if (started_r) cur = slot_r;
    else if (head_cmd.sc) cur = SL_SC0;
    else if (head_cmd.data) cur = SL_DATA;
    else cur = SL_STAT;

    slot_nxt   = SL_STAT;
    is_last    = 1'b1;
    byte_nxt   = avcc_pkg::START_CODE_PAD;
    status_nxt = avcc_pkg::ST_BYTE;
    ustart_nxt = 1'b0;
    uend_nxt   = 1'b0;
    kind_nxt   = head_cmd.kind;
    unique case (cur)
      SL_SC0: begin
        slot_nxt   = SL_SC1;
        is_last    = 1'b0;
        ustart_nxt = 1'b1;
      end
      SL_SC1: begin
        slot_nxt = SL_SC2;
        is_last  = 1'b0;
      end
      SL_SC2: begin
        slot_nxt = SL_SC3;
        is_last  = 1'b0;
      end
      SL_SC3: begin
        byte_nxt = avcc_pkg::START_CODE_END;
        uend_nxt = head_cmd.sc_end;
        slot_nxt = head_cmd.data ? SL_DATA : SL_STAT;
        is_last  = !head_cmd.data && !has_stat;
      end
      SL_DATA: begin
        byte_nxt = head_cmd.data_byte;
        uend_nxt = head_cmd.data_end;
        slot_nxt = SL_STAT;
        is_last  = !has_stat;
      end
      SL_STAT: begin
        status_nxt = head_cmd.status;
        kind_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign load = head_valid && (!out_valid_r || out_tready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      slot_r      <= SL_SC0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        started_r   <= !is_last;
        slot_r      <= slot_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_nxt;
      status_r  <= status_nxt;
      ustart_r  <= ustart_nxt;
      uend_r    <= uend_nxt;
      kind_r    <= kind_nxt;
      last_r    <= is_last;
      profile_r <= head_cmd.profile;
      level_r   <= head_cmd.level;
      nal_len_r <= head_cmd.nal_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, nal_len_r, level_r, profile_r, byte_r};
  assign out_tuser  = {kind_r, uend_r, ustart_r, status_r};
  assign out_tlast  = last_r;

endmodule

[hw/rtl/avcc_record_to_annexb.sv]
// Channel  Dir  tdata (low bits up)                     tuser (low bits up)        tlast
// in_      in   in_byte                                 none                       record_last
// out_     out  out_byte, profile, level, nal length    status, start, end, kind   run_last
// One input byte is taken per cycle while the command queue has room; the parser
// decides each byte in the cycle it is accepted. The emitter sends one item per cycle while
// the output is ready, so a byte that carries a length low byte yields four or five output items.
// Reset is synchronous and active low; it clears the parser, the queue and the output valid
// register. The input stalls only when the four-entry queue is full.
// Top level: parser, command queue and emitter; depends on avcc_pkg and the macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module avcc_record_to_annexb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [15:8] profile_code, [23:16] level_code,
                                  // [26:24] nal_length_bytes
  output logic [4:0]  out_tuser,  // [1:0] status, [2] unit_start, [3] unit_end, [4] unit_kind
  output logic        out_tlast
);

  logic           accept, push, full, head_valid, pop;
  avcc_pkg::cmd_t push_cmd, head_cmd;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  avcc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .cmd     (push_cmd)
  );

  avcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  avcc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `ASRT_IMPL(a_full_has_head, !in_tready, head_valid, "queue full but reports empty")
  `ASRT_IMPL(a_start_not_last, out_tvalid && out_tuser[2],
             !out_tlast && out_tdata[7:0] == 8'd0,
             "unit start item must lead a start code")
  `ASRT_IMPL(a_status_clean, out_tvalid && out_tuser[1:0] != avcc_pkg::ST_BYTE,
             out_tdata[7:0] == 8'd0 && out_tuser[4:2] == 3'd0 && out_tlast,
             "status item malformed")

endmodule
